// ===== design/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpd_pkg: shared constants and types for the triangle point test block
// Holds the default widths, the operation codes and the item field layout.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DEPTH_BITS     = 32;
  localparam int QUO_BITS       = DEPTH_BITS + 1;
  localparam int QDEPTH         = 2;

  // Field positions inside a queued word, most significant first after the op bit.
  localparam int NUM_FIELDS = 11;
  localparam int F_AX = 0;
  localparam int F_AY = 1;
  localparam int F_AZ = 2;
  localparam int F_BX = 3;
  localparam int F_BY = 4;
  localparam int F_BZ = 5;
  localparam int F_CX = 6;
  localparam int F_CY = 7;
  localparam int F_CZ = 8;
  localparam int F_PX = 9;
  localparam int F_PY = 10;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

// ===== design/tpd_if.sv =====
// ----------------------------------------------------------------------------
// tpd_if: input and result channels
// Valid/ready channels carrying one word each.
// ----------------------------------------------------------------------------
interface tpd_in_if #(
  parameter int COORD_BITS = tpd_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] az;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] bz;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  modport source (output valid, mode, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py,
                  input ready);
  modport sink   (input valid, mode, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py,
                  output ready);
endinterface

interface tpd_out_if ();
  logic                                   valid;
  logic                                   ready;
  logic                                   inside_res;
  logic signed [tpd_pkg::DEPTH_BITS-1:0]  depth;
  logic                                   depth_valid;

  modport source (output valid, inside_res, depth, depth_valid, input ready);
  modport sink   (input valid, inside_res, depth, depth_valid, output ready);
endinterface

// ===== design/tpd_front.sv =====
// ----------------------------------------------------------------------------
// tpd_front: input word decode
// Classifies each word as load or query and packs only the fields it uses.
// ----------------------------------------------------------------------------
module tpd_front #(
  parameter int COORD_BITS = tpd_pkg::COORD_BITS_DEF,
  localparam int W = 1 + tpd_pkg::NUM_FIELDS * COORD_BITS
) (
  tpd_in_if.sink          in_if,
  input  logic            full,
  output logic            push,
  output logic [W-1:0]    push_data
);

  logic is_query;

  assign is_query    = (in_if.mode == tpd_pkg::OP_QUERY);
  assign in_if.ready = !full;
  assign push        = in_if.valid && !full;

  // Unused fields are zeroed so the back end never sees stale coordinates.
  always_comb begin
    if (is_query) begin
      push_data = {tpd_pkg::OP_QUERY, {(9*COORD_BITS){1'b0}}, in_if.px, in_if.py};
    end else begin
      push_data = {tpd_pkg::OP_LOAD, in_if.ax, in_if.ay, in_if.az,
                   in_if.bx, in_if.by_coord, in_if.bz,
                   in_if.cx, in_if.cy, in_if.cz, {(2*COORD_BITS){1'b0}}};
    end
  end

endmodule

// ===== design/tpd_queue.sv =====
// ----------------------------------------------------------------------------
// tpd_queue: small word queue
// Two-entry queue between the decode front and the compute back end.
// ----------------------------------------------------------------------------
module tpd_queue #(
  parameter int W = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output logic [W-1:0]  head
);

  localparam int PW = $clog2(tpd_pkg::QDEPTH);

  logic [W-1:0]  mem [tpd_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full      = (count_r == (PW+1)'(tpd_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop) count_r <= count_r + (PW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (PW+1)'(1);
    end
  end

endmodule

// ===== design/tpd_back.sv =====
// ----------------------------------------------------------------------------
// tpd_back: triangle setup, point test and depth divider
// Sequencer that runs loads and queries one at a time with a radix-2 divider.
// ----------------------------------------------------------------------------
module tpd_back #(
  parameter int COORD_BITS = tpd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tpd_pkg::FRAC_BITS_DEF,
  localparam int W = 1 + tpd_pkg::NUM_FIELDS * COORD_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          has_item,
  input  logic [W-1:0]  item,
  output logic          pop,
  tpd_out_if.source     out_if
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int PPW = 2*C + 2;
  localparam int NW  = 2*C + 3;
  localparam int TW  = 3*C + 3;
  localparam int OW  = 3*C + 6;
  localparam int SW  = 3*C + 7;
  localparam int MW  = SW + FRAC_BITS;
  localparam int QB  = tpd_pkg::QUO_BITS;
  localparam int XW  = MW + QB;
  localparam int RW  = NW + 1;
  localparam int DB  = tpd_pkg::DEPTH_BITS;
  localparam int CW  = $clog2(QB);
  localparam logic [QB-1:0] LIM = QB'(1) << (DB-1);

  typedef enum logic [3:0] {
    S_IDLE, S_L1, S_L2, S_L3, S_L4, S_L5,
    S_Q1, S_Q2, S_Q3, S_Q4, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  logic [W-1:0]           cmd_r;
  logic signed [C-1:0]    fld [tpd_pkg::NUM_FIELDS];
  logic signed [C-1:0]    vx_r [3];
  logic signed [C-1:0]    vy_r [3];
  logic signed [NW-1:0]   nx_r, ny_r, nz_r;
  logic signed [OW-1:0]   off_r;
  logic signed [DW-1:0]   da_r [6];
  logic signed [PPW-1:0]  pa_r [6];
  logic signed [TW-1:0]   t_r [3];
  logic signed [SW-1:0]   num_r;
  logic                   inside_r;
  logic                   neg_r;
  logic [SW-1:0]          mn_r;
  logic [NW-1:0]          mc_r;
  logic [NW-1:0]          rem_r;
  logic [QB-1:0]          lo_r;
  logic [QB-1:0]          q_r;
  logic [CW-1:0]          cnt_r;
  logic                   valid_r;
  logic                   res_inside_r;
  logic signed [DB-1:0]   res_depth_r;
  logic                   res_dv_r;

  // Query combinational helpers.
  logic signed [NW-1:0]   e [3];
  logic                   has_neg, has_pos;
  logic signed [SW-1:0]   nneg;
  logic [XW-1:0]          nx_wide;
  logic [MW-1:0]          hi;
  logic [RW-1:0]          rs;
  logic                   qbit;

  always_comb begin
    for (int k = 0; k < tpd_pkg::NUM_FIELDS; k++) begin
      fld[k] = $signed(cmd_r[(tpd_pkg::NUM_FIELDS-1-k)*C +: C]);
    end
  end

  always_comb begin
    has_neg = 1'b0;
    has_pos = 1'b0;
    for (int k = 0; k < 3; k++) begin
      e[k] = NW'(pa_r[2*k]) - NW'(pa_r[2*k+1]);
      has_neg = has_neg | e[k][NW-1];
      has_pos = has_pos | (!e[k][NW-1] && (e[k] != '0));
    end
  end

  assign nneg    = SW'(0) - num_r;
  assign nx_wide = XW'(MW'(mn_r) << FRAC_BITS);
  assign hi      = nx_wide[XW-1:QB];
  assign rs      = {rem_r, lo_r[QB-1]};
  assign qbit    = (rs >= RW'(mc_r));

  assign pop = (state_r == S_IDLE) && has_item && !valid_r;

  assign out_if.valid       = valid_r;
  assign out_if.inside_res  = res_inside_r;
  assign out_if.depth       = res_depth_r;
  assign out_if.depth_valid = res_dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        vx_r[k] <= '0;
        vy_r[k] <= '0;
      end
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= '0;
      off_r <= '0;
      cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            cmd_r   <= item;
            state_r <= (item[W-1] == tpd_pkg::OP_QUERY) ? S_Q1 : S_L1;
          end
        end
        // Edge vectors u = C - B and w = C - A.
        S_L1: begin
          da_r[0] <= DW'(fld[tpd_pkg::F_CX]) - DW'(fld[tpd_pkg::F_BX]);
          da_r[1] <= DW'(fld[tpd_pkg::F_CY]) - DW'(fld[tpd_pkg::F_BY]);
          da_r[2] <= DW'(fld[tpd_pkg::F_CZ]) - DW'(fld[tpd_pkg::F_BZ]);
          da_r[3] <= DW'(fld[tpd_pkg::F_CX]) - DW'(fld[tpd_pkg::F_AX]);
          da_r[4] <= DW'(fld[tpd_pkg::F_CY]) - DW'(fld[tpd_pkg::F_AY]);
          da_r[5] <= DW'(fld[tpd_pkg::F_CZ]) - DW'(fld[tpd_pkg::F_AZ]);
          state_r <= S_L2;
        end
        S_L2: begin
          pa_r[0] <= PPW'(da_r[1]) * PPW'(da_r[5]);
          pa_r[1] <= PPW'(da_r[4]) * PPW'(da_r[2]);
          pa_r[2] <= PPW'(da_r[3]) * PPW'(da_r[2]);
          pa_r[3] <= PPW'(da_r[0]) * PPW'(da_r[5]);
          pa_r[4] <= PPW'(da_r[0]) * PPW'(da_r[4]);
          pa_r[5] <= PPW'(da_r[3]) * PPW'(da_r[1]);
          state_r <= S_L3;
        end
        S_L3: begin
          nx_r    <= NW'(pa_r[0]) - NW'(pa_r[1]);
          ny_r    <= NW'(pa_r[2]) - NW'(pa_r[3]);
          nz_r    <= NW'(pa_r[4]) - NW'(pa_r[5]);
          state_r <= S_L4;
        end
        S_L4: begin
          t_r[0]  <= TW'(nx_r) * TW'(fld[tpd_pkg::F_AX]);
          t_r[1]  <= TW'(ny_r) * TW'(fld[tpd_pkg::F_AY]);
          t_r[2]  <= TW'(nz_r) * TW'(fld[tpd_pkg::F_AZ]);
          state_r <= S_L5;
        end
        S_L5: begin
          off_r   <= OW'(0) - (OW'(t_r[0]) + OW'(t_r[1]) + OW'(t_r[2]));
          vx_r[0] <= fld[tpd_pkg::F_AX];
          vy_r[0] <= fld[tpd_pkg::F_AY];
          vx_r[1] <= fld[tpd_pkg::F_BX];
          vy_r[1] <= fld[tpd_pkg::F_BY];
          vx_r[2] <= fld[tpd_pkg::F_CX];
          vy_r[2] <= fld[tpd_pkg::F_CY];
          state_r <= S_IDLE;
        end
        // Edge k runs from vertex k to vertex k+1 (wrapping).
        S_Q1: begin
          for (int k = 0; k < 3; k++) begin
            da_r[2*k]   <= DW'(fld[tpd_pkg::F_PX]) - DW'(vx_r[(k+1)%3]);
            da_r[2*k+1] <= DW'(vy_r[k]) - DW'(vy_r[(k+1)%3]);
          end
          t_r[0]  <= TW'(nx_r) * TW'(fld[tpd_pkg::F_PX]);
          t_r[1]  <= TW'(ny_r) * TW'(fld[tpd_pkg::F_PY]);
          state_r <= S_Q2;
        end
        S_Q2: begin
          for (int k = 0; k < 3; k++) begin
            pa_r[2*k]   <= PPW'(da_r[2*k]) * PPW'(da_r[2*k+1]);
            pa_r[2*k+1] <= (PPW'(vx_r[k]) - PPW'(vx_r[(k+1)%3]))
                         * (PPW'(fld[tpd_pkg::F_PY]) - PPW'(vy_r[(k+1)%3]));
          end
          num_r   <= SW'(off_r) + SW'(t_r[0]) + SW'(t_r[1]);
          state_r <= S_Q3;
        end
        S_Q3: begin
          inside_r <= !(has_neg && has_pos);
          neg_r    <= nneg[SW-1] ^ nz_r[NW-1];
          mn_r     <= nneg[SW-1] ? (SW'(0) - nneg) : nneg;
          mc_r     <= nz_r[NW-1] ? (NW'(0) - nz_r) : nz_r;
          state_r  <= S_Q4;
        end
        S_Q4: begin
          q_r <= '0;
          if (mc_r == '0) begin
            valid_r      <= 1'b1;
            res_inside_r <= inside_r;
            res_depth_r  <= '0;
            res_dv_r     <= 1'b0;
            state_r      <= S_OUT;
          end else if (hi >= MW'(mc_r)) begin
            // The quotient cannot fit even before the final clamp.
            valid_r      <= 1'b1;
            res_inside_r <= inside_r;
            res_depth_r  <= neg_r ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
            res_dv_r     <= 1'b1;
            state_r      <= S_OUT;
          end else begin
            rem_r   <= NW'(hi);
            lo_r    <= nx_wide[QB-1:0];
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= qbit ? NW'(rs - RW'(mc_r)) : NW'(rs);
          lo_r  <= {lo_r[QB-2:0], 1'b0};
          q_r   <= {q_r[QB-2:0], qbit};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(QB-1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          valid_r      <= 1'b1;
          res_inside_r <= inside_r;
          res_dv_r     <= 1'b1;
          if (neg_r) begin
            res_depth_r <= (q_r > LIM) ? {1'b1, {(DB-1){1'b0}}} : DB'(QB'(0) - q_r);
          end else begin
            res_depth_r <= (q_r >= LIM) ? {1'b0, {(DB-1){1'b1}}} : DB'(q_r);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_if.ready) begin
            valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < mc_r))
    else $error("divider remainder not below divisor");

  a_no_depth_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !res_dv_r) |-> (res_depth_r == '0))
    else $error("depth nonzero while depth_valid is low");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CW'(QB-1)))
    else $error("divider step count overran");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_if.ready) |=> (valid_r && (state_r == S_OUT)))
    else $error("pending result dropped by back end");

endmodule

// ===== design/triangle_point_test_and_depth.sv =====
// ----------------------------------------------------------------------------
// triangle_point_test_and_depth: point-in-triangle test with plane depth
// Loads a triangle, then answers point queries with inside flag and Q16.16 depth.
// ----------------------------------------------------------------------------
// A load word (mode 0) gives no result; it computes the plane normal and offset
// from the three vertices. A query word (mode 1) gives one result word: the
// inside flag (points on an edge count as inside), and the plane depth at the
// point, truncated toward zero and clamped. The depth comes from the radix-2
// divider, which retires one of 33 quotient bits per cycle; a zero normal z or
// a clearly overflowing quotient skips the divider. A two-word queue sits
// between the input decode and the back end, so input words keep being taken
// while a result word waits on the output, until the queue is full. No clearing
// pass is needed.
module triangle_point_test_and_depth #(
  parameter int COORD_BITS = tpd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tpd_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tpd_in_if.sink      in_if,
  tpd_out_if.source   out_if
);

  localparam int W = 1 + tpd_pkg::NUM_FIELDS * COORD_BITS;

  logic          q_full;
  logic          q_push;
  logic [W-1:0]  q_push_data;
  logic          q_pop;
  logic          q_not_empty;
  logic [W-1:0]  q_head;

  // Decode: accept a word whenever the queue has room.
  tpd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_if     (in_if),
    .full      (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  tpd_queue #(.W(W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back end: triangle setup, edge tests and the depth divider.
  tpd_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .has_item (q_not_empty),
    .item     (q_head),
    .pop      (q_pop),
    .out_if   (out_if)
  );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the triangle point test and depth block
// Drives load and query words over the valid/ready input channel, predicts
// the inside flag and the Q16.16 plane depth of each query with a local
// integer model, and checks every result word in order under random idling
// on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF   = 6;
  localparam int CYCLE_CAP  = 2000000;
  localparam int DRAIN_WAIT = 80;

  // One input word as the testbench sees it.
  typedef struct {
    tpd_pkg::op_t       mode;
    logic signed [15:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py;
  } tri_word_t;

  // One expected result word.
  typedef struct {
    logic        inside_res;
    logic [31:0] depth;
    logic        depth_valid;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tpd_in_if  in_ch ();
  tpd_out_if out_ch ();

  triangle_point_test_and_depth u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // Shadow of the block's triangle: vertex x/y and the plane equation.
  longint tri_x [3];
  longint tri_y [3];
  longint plane_nx, plane_ny, plane_nz, plane_d;

  hit_t   hits_due [$];
  int     mismatches = 0;
  int     cycle_count = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     rx_hold_left = 0;

  // Sign of the edge function of edge U-V evaluated at (x, y).
  function automatic int edge_sign(longint x, longint y, int u, int v);
    longint e;
    e = (x - tri_x[v]) * (tri_y[u] - tri_y[v]) - (tri_x[u] - tri_x[v]) * (y - tri_y[v]);
    return (e > 0) ? 1 : ((e < 0) ? -1 : 0);
  endfunction

  // Plane depth at (x, y): integer quotient first, then one fraction bit per
  // step by restoring division, truncated toward zero and clamped to 32 bits.
  function automatic logic [31:0] plane_depth(longint x, longint y);
    longint          num, n;
    longint unsigned mn, mc, q, r;
    logic            neg;
    num = plane_d + plane_nx * x + plane_ny * y;
    n   = -num;
    neg = (n < 0) != (plane_nz < 0);
    mn  = (n < 0) ? longint'(-n) : n;
    mc  = (plane_nz < 0) ? longint'(-plane_nz) : plane_nz;
    q   = mn / mc;
    r   = mn % mc;
    if (q >= 64'h1_0000_0000) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    for (int i = 0; i < tpd_pkg::FRAC_BITS_DEF; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= mc) begin
        r = r - mc;
        q = q | 64'd1;
      end
    end
    if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // Update the triangle shadow on a load, or queue the expected result of a query.
  function automatic void predict_word(tri_word_t w);
    longint x1, y1, z1, x2, y2, z2, x3, y3, z3, ux, uy, uz, vx, vy, vz;
    int     s1, s2, s3;
    hit_t   h;
    if (w.mode == tpd_pkg::OP_LOAD) begin
      x1 = w.ax; y1 = w.ay; z1 = w.az;
      x2 = w.bx; y2 = w.by_coord; z2 = w.bz;
      x3 = w.cx; y3 = w.cy; z3 = w.cz;
      ux = x3 - x2; uy = y3 - y2; uz = z3 - z2;
      vx = x3 - x1; vy = y3 - y1; vz = z3 - z1;
      plane_nx = uy * vz - vy * uz;
      plane_ny = vx * uz - ux * vz;
      plane_nz = ux * vy - vx * uy;
      plane_d  = -(plane_nx * x1 + plane_ny * y1 + plane_nz * z1);
      tri_x[0] = x1; tri_y[0] = y1;
      tri_x[1] = x2; tri_y[1] = y2;
      tri_x[2] = x3; tri_y[2] = y3;
    end else begin
      s1 = edge_sign(w.px, w.py, 0, 1);
      s2 = edge_sign(w.px, w.py, 1, 2);
      s3 = edge_sign(w.px, w.py, 2, 0);
      h.inside_res = !((s1 < 0 || s2 < 0 || s3 < 0) && (s1 > 0 || s2 > 0 || s3 > 0));
      if (plane_nz == 0) begin
        h.depth       = '0;
        h.depth_valid = 1'b0;
      end else begin
        h.depth       = plane_depth(w.px, w.py);
        h.depth_valid = 1'b1;
      end
      hits_due.push_back(h);
    end
  endfunction

  // Drive one word at the falling edge and hold it until it is taken. Valid is
  // left high so that back-to-back words never see a drop within a step.
  task automatic send_word(tri_word_t w);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.mode     = w.mode;
    in_ch.ax       = w.ax;  in_ch.ay = w.ay;  in_ch.az = w.az;
    in_ch.bx       = w.bx;  in_ch.by_coord = w.by_coord;  in_ch.bz = w.bz;
    in_ch.cx       = w.cx;  in_ch.cy = w.cy;  in_ch.cz = w.cz;
    in_ch.px       = w.px;  in_ch.py = w.py;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(w);
  endtask

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // A word with every field random, so that unused fields toggle too.
  function automatic tri_word_t noise_word(tpd_pkg::op_t m);
    tri_word_t w;
    w.mode = m;
    w.ax = 16'($urandom); w.ay = 16'($urandom); w.az = 16'($urandom);
    w.bx = 16'($urandom); w.by_coord = 16'($urandom); w.bz = 16'($urandom);
    w.cx = 16'($urandom); w.cy = 16'($urandom); w.cz = 16'($urandom);
    w.px = 16'($urandom); w.py = 16'($urandom);
    return w;
  endfunction

  function automatic tri_word_t load_of(int x1, int y1, int z1, int x2, int y2, int z2,
                                        int x3, int y3, int z3);
    tri_word_t w;
    w = noise_word(tpd_pkg::OP_LOAD);
    w.ax = 16'(x1); w.ay = 16'(y1); w.az = 16'(z1);
    w.bx = 16'(x2); w.by_coord = 16'(y2); w.bz = 16'(z2);
    w.cx = 16'(x3); w.cy = 16'(y3); w.cz = 16'(z3);
    return w;
  endfunction

  function automatic tri_word_t query_of(int x, int y);
    tri_word_t w;
    w = noise_word(tpd_pkg::OP_QUERY);
    w.px = 16'(x); w.py = 16'(y);
    return w;
  endfunction

  // Stop offering the last word, then wait until every expected result word
  // has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
  endtask

  // Corner cases: reset state, extremes, edges and vertices, collinear
  // triangles and a tiny triangle whose depth overflows in both directions.
  task automatic test_directed();
    send_word(query_of(0, 0));
    send_word(query_of(-32768, 32767));
    send_word(load_of(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767));
    send_word(query_of(-32768, -32768));
    send_word(query_of(32767, 32767));
    send_word(query_of(0, 0));
    send_word(query_of(-100, -32768));
    send_word(load_of(32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768));
    send_word(query_of(-32768, -32768));
    send_word(query_of(0, 0));
    // Collinear vertices leave the normal z at zero.
    send_word(load_of(0, 0, 5, 10, 10, 7, 20, 20, 9));
    send_word(query_of(5, 5));
    send_word(query_of(3, 9));
    // Unit triangle with steep depth: the quotient clamps high and low.
    send_word(load_of(0, 0, -32768, 1, 0, 32767, 0, 1, 0));
    send_word(query_of(0, 0));
    send_word(query_of(32767, 32767));
    send_word(query_of(-32768, 32767));
    send_word(load_of(0, 0, 32767, 1, 0, -32768, 0, 1, 0));
    send_word(query_of(32767, -32768));
    // Plain triangle: a vertex, an edge midpoint, inside and outside points.
    send_word(load_of(-40, -40, 100, 40, -40, -200, 0, 40, 300));
    send_word(query_of(40, -40));
    send_word(query_of(20, 0));
    send_word(query_of(1, 1));
    send_word(query_of(100, 100));
    drain();
  endtask

  // Random triangles, each followed by a run of queries near it. A few words
  // are pure noise so that every bit of every field is exercised.
  task automatic test_random(int words, int tx_pct, int rx_pct);
    int scale, bx0, by0, x1, y1, x2, y2, x3, y3, k, nq, sent;
    tri_word_t w;
    tri_word_t ld;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(99) < 8) begin
        send_word(noise_word($urandom_range(1) ? tpd_pkg::OP_QUERY : tpd_pkg::OP_LOAD));
        sent++;
        continue;
      end
      case ($urandom_range(2))
        0: scale = 64;
        1: scale = 2000;
        default: scale = 0;
      endcase
      if (scale == 0) begin
        w = noise_word(tpd_pkg::OP_LOAD);
      end else begin
        bx0 = rnd(-30000, 30000);
        by0 = rnd(-30000, 30000);
        x1 = bx0 + rnd(-scale, scale); y1 = by0 + rnd(-scale, scale);
        x2 = bx0 + rnd(-scale, scale); y2 = by0 + rnd(-scale, scale);
        case ($urandom_range(9))
          0: begin
            // Collinear third vertex.
            k = rnd(-1, 2);
            x3 = x1 + k * (x2 - x1) / 2; y3 = y1 + k * (y2 - y1) / 2;
          end
          1: begin
            // Nearly degenerate triangle for large depths.
            x2 = x1 + 1; y2 = y1; x3 = x1; y3 = y1 + 1;
          end
          default: begin
            x3 = bx0 + rnd(-scale, scale); y3 = by0 + rnd(-scale, scale);
          end
        endcase
        w = load_of(x1, y1, rnd(-32768, 32767), x2, y2, rnd(-32768, 32767),
                    x3, y3, rnd(-32768, 32767));
      end
      send_word(w);
      sent++;
      // Keep the loaded vertices, since w is reused for each query below.
      ld = w;
      nq = $urandom_range(1, 6);
      for (int i = 0; i < nq; i++) begin
        case ($urandom_range(9))
          0: w = query_of(ld.ax, ld.ay);
          1: w = query_of((ld.ax + ld.bx) >>> 1, (ld.ay + ld.by_coord) >>> 1);
          2: w = noise_word(tpd_pkg::OP_QUERY);
          default: begin
            if (scale == 0) w = noise_word(tpd_pkg::OP_QUERY);
            else w = query_of(bx0 + rnd(-scale - 8, scale + 8),
                              by0 + rnd(-scale - 8, scale + 8));
          end
        endcase
        send_word(w);
        sent++;
      end
    end
    drain();
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering
  // queries, so the internal queue fills and input ready drops.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_word(load_of(-500, -300, 1000, 700, -200, -800, 100, 900, 50));
    rx_hold_left = 600;
    for (int i = 0; i < 40; i++) send_word(query_of(rnd(-600, 800), rnd(-400, 1000)));
    drain();
  endtask

  // Output ready is chosen at each falling edge; a pending hold-off wins.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ch.ready = 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    hit_t h;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: inside %0b depth %h dv %0b",
                                       out_ch.inside_res, out_ch.depth, out_ch.depth_valid);
      end else begin
        h = hits_due.pop_front();
        if (out_ch.inside_res !== h.inside_res || out_ch.depth !== h.depth ||
            out_ch.depth_valid !== h.depth_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected inside %0b depth %h dv %0b, got %0b %h %0b",
                     h.inside_res, h.depth, h.depth_valid,
                     out_ch.inside_res, out_ch.depth, out_ch.depth_valid);
        end
      end
    end
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode  = tpd_pkg::OP_LOAD;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_coord, in_ch.bz} = '0;
    {in_ch.cx, in_ch.cy, in_ch.cz, in_ch.px, in_ch.py} = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tri_x[i] = 0;
      tri_y[i] = 0;
    end
    plane_nx = 0; plane_ny = 0; plane_nz = 0; plane_d = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(520, 30, 83);
    test_random(520, 83, 30);
    test_random(520, 0, 0);
    test_backpressure();

    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && hits_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
